FILE: hw/rtl/frc_pkg.sv
// frc_pkg: shared types, codes and the crc-16/ccitt-false byte update
// for the frame receiver; no dependencies
package frc_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] REG_HEADER_BYTE = 2'd0;
  localparam logic [1:0] REG_LOCAL_ADDR  = 2'd1;
  localparam logic [1:0] REG_BCAST_ADDR  = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADHDR = 3'd1;
  localparam logic [2:0] ST_SHORT  = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_ADDR   = 3'd4;

  localparam logic [8:0]  HDR_LEN  = 9'd11;
  localparam logic [8:0]  MIN_LEN  = 9'd13;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  status;
    logic [7:0]  src_address;
    logic [7:0]  dest_address;
    logic [15:0] sequence_res;
    logic [15:0] domain;
    logic [7:0]  message_type;
    logic [7:0]  flags_byte;
    logic [7:0]  payload_length;
    logic [15:0] received_crc;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] local_address;
    logic [7:0] broadcast_address;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

endpackage

FILE: hw/rtl/frc_chan_if.sv
// frc_chan_if: valid/ready channel carrying one payload beat
// payload type is set per instance, normally from frc_pkg
interface frc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/frc_cfg_regs.sv
// frc_cfg_regs: apb-style register file for header byte and addresses
// depends on frc_pkg
module frc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [frc_pkg::CfgDataW-1:0]  pwdata,
  output logic [frc_pkg::CfgDataW-1:0]  prdata,
  output frc_pkg::cfg_t                 cfg
);

  frc_pkg::cfg_t cfg_r;
  frc_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        frc_pkg::REG_HEADER_BYTE: cfg_nxt.header_byte       = pwdata[7:0];
        frc_pkg::REG_LOCAL_ADDR:  cfg_nxt.local_address     = pwdata[7:0];
        frc_pkg::REG_BCAST_ADDR:  cfg_nxt.broadcast_address = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte       <= 8'hAA;
      cfg_r.local_address     <= 8'h00;
      cfg_r.broadcast_address <= 8'hFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      frc_pkg::REG_HEADER_BYTE: prdata = {24'h0, cfg_r.header_byte};
      frc_pkg::REG_LOCAL_ADDR:  prdata = {24'h0, cfg_r.local_address};
      frc_pkg::REG_BCAST_ADDR:  prdata = {24'h0, cfg_r.broadcast_address};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/frc_parser.sv
// frc_parser: per-byte frame state, header capture, crc check and result build
// depends on frc_pkg
module frc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  frc_pkg::in_item_t   item,
  input  frc_pkg::cfg_t       cfg,
  output logic                res_valid,
  output frc_pkg::out_item_t  res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FRAME  = 2'd1;
  localparam logic [1:0] PH_BADHDR = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  logic [1:0]  phase_r,     phase_nxt;
  logic [8:0]  cnt_r,       cnt_nxt;
  logic [15:0] crc_r,       crc_nxt;
  logic [7:0]  src_r,       src_nxt;
  logic [7:0]  dest_r,      dest_nxt;
  logic [15:0] seq_r,       seq_nxt;
  logic [15:0] dom_r,       dom_nxt;
  logic [7:0]  type_r,      type_nxt;
  logic [7:0]  flags_r,     flags_nxt;
  logic [7:0]  len_r,       len_nxt;
  logic [7:0]  crc_lo_r,    crc_lo_nxt;

  logic [7:0]  b;
  logic        last;
  logic [8:0]  cnt_inc;
  logic [15:0] rcrc;
  logic [15:0] crc_upd;

  assign b       = item.data_byte;
  assign last    = item.last_byte;
  assign cnt_inc = cnt_r + 9'd1;
  assign rcrc    = {b, crc_lo_r};
  assign crc_upd = frc_pkg::crc16_byte(crc_r, b);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    src_nxt    = src_r;
    dest_nxt   = dest_r;
    seq_nxt    = seq_r;
    dom_nxt    = dom_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    len_nxt    = len_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_IDLE: begin
        cnt_nxt    = 9'd1;
        crc_nxt    = frc_pkg::CRC_INIT;
        src_nxt    = '0;
        dest_nxt   = '0;
        seq_nxt    = '0;
        dom_nxt    = '0;
        type_nxt   = '0;
        flags_nxt  = '0;
        len_nxt    = '0;
        crc_lo_nxt = '0;
        if (last) begin
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = frc_pkg::ST_SHORT;
        end else if (b == cfg.header_byte) begin
          crc_nxt   = frc_pkg::crc16_byte(frc_pkg::CRC_INIT, b);
          phase_nxt = PH_FRAME;
        end else begin
          phase_nxt = PH_BADHDR;
        end
      end
      PH_BADHDR: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= frc_pkg::MIN_LEN) begin
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = frc_pkg::ST_BADHDR;
          phase_nxt  = last ? PH_IDLE : PH_SKIP;
        end else if (last) begin
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = frc_pkg::ST_SHORT;
          phase_nxt  = PH_IDLE;
        end
      end
      PH_SKIP: begin
        if (last) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        cnt_nxt = cnt_inc;
        if (cnt_r == frc_pkg::HDR_LEN + 9'd1 + {1'b0, len_r}) begin
          res_valid          = 1'b1;
          res.kind           = 1'b1;
          res.src_address    = src_r;
          res.dest_address   = dest_r;
          res.sequence_res   = seq_r;
          res.domain         = dom_r;
          res.message_type   = type_r;
          res.flags_byte     = flags_r;
          res.payload_length = len_r;
          res.received_crc   = rcrc;
          if (rcrc != crc_r) begin
            res.status = frc_pkg::ST_CRC;
          end else if (dest_r != cfg.local_address && dest_r != cfg.broadcast_address) begin
            res.status = frc_pkg::ST_ADDR;
          end else begin
            res.status = frc_pkg::ST_OK;
          end
          phase_nxt = last ? PH_IDLE : PH_SKIP;
        end else if (last) begin
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = frc_pkg::ST_SHORT;
          phase_nxt  = PH_IDLE;
        end else if (cnt_r < frc_pkg::HDR_LEN) begin
          crc_nxt = crc_upd;
          case (cnt_r[3:0])
            4'd2:    flags_nxt = b;
            4'd3:    src_nxt   = b;
            4'd4:    dest_nxt  = b;
            4'd5:    seq_nxt   = {seq_r[15:8], b};
            4'd6:    seq_nxt   = {b, seq_r[7:0]};
            4'd7:    dom_nxt   = {dom_r[15:8], b};
            4'd8:    dom_nxt   = {b, dom_r[7:0]};
            4'd9:    type_nxt  = b;
            4'd10:   len_nxt   = b;
            default: ;
          endcase
        end else if (cnt_r < frc_pkg::HDR_LEN + {1'b0, len_r}) begin
          crc_nxt           = crc_upd;
          res_valid         = 1'b1;
          res.kind          = 1'b0;
          res.payload_byte  = b;
          res.payload_index = 8'(cnt_r - frc_pkg::HDR_LEN);
        end else begin
          crc_lo_nxt = b;
        end
      end
    endcase

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      crc_r    <= frc_pkg::CRC_INIT;
      src_r    <= '0;
      dest_r   <= '0;
      seq_r    <= '0;
      dom_r    <= '0;
      type_r   <= '0;
      flags_r  <= '0;
      len_r    <= '0;
      crc_lo_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      src_r    <= src_nxt;
      dest_r   <= dest_nxt;
      seq_r    <= seq_nxt;
      dom_r    <= dom_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      len_r    <= len_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

FILE: hw/rtl/frame_receiver_crc16_addr_filter.sv
// frame_receiver_crc16_addr_filter: top level with input and result registers
// depends on frc_pkg, frc_chan_if, frc_cfg_regs, frc_parser
//
// bytes of a received buffer arrive on in_chan, one beat each, with
// last_byte set on the final byte of the buffer. the frame is checked for
// its header byte, the 11-byte header is captured, payload bytes leave on
// out_chan as kind 0 beats, and one kind 1 summary beat per buffer gives
// the status (ok, bad header, too short, crc mismatch, not addressed).
// bytes after a frame are dropped up to the last_byte flag.
// header byte, local and broadcast address are set through the apb port
// at byte addresses 0, 4 and 8; write them only while the block is idle.
// each byte is registered on accept in the input register, processed by the
// frame state logic once the output register is free, and its result (if any)
// lands in the output register, from which out_chan takes it; while out_chan
// does not stall, one byte is taken every cycle, with the crc updated one
// byte at a time.
// when out_chan stalls, the held result keeps one byte waiting in the
// input register and in_chan.ready drops until the result is taken.
// synchronous reset restores the register defaults (0xaa, 0x00, 0xff),
// empties both registers and returns the parser to awaiting a header byte.
module frame_receiver_crc16_addr_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  frc_chan_if.sink                      in_chan,
  frc_chan_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [frc_pkg::CfgDataW-1:0]  pwdata,
  output logic [frc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  frc_pkg::cfg_t      cfg;
  frc_pkg::in_item_t  in_r,        in_nxt;
  logic               in_valid_r,  in_valid_nxt;
  frc_pkg::out_item_t out_r,       out_nxt;
  logic               out_valid_r, out_valid_nxt;
  frc_pkg::out_item_t res;
  logic               res_valid;
  logic               step;
  logic               in_take;

  assign pready = 1'b1;

  frc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign step          = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || step;
  assign in_take       = in_chan.valid && in_chan.ready;

  frc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_nxt       = in_take ? in_chan.payload : in_r;
    in_valid_nxt = in_take || (in_valid_r && !step);
    out_nxt      = res_valid ? res : out_r;
    out_valid_nxt = res_valid || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_chan.ready))
    else $error("result produced while output register still full");

  a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step) |=> in_valid_r)
    else $error("pending input byte lost");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.kind) |-> (out_r.status == frc_pkg::ST_OK))
    else $error("payload beat carries a status");

  a_summary_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind) |-> (out_r.status <= frc_pkg::ST_ADDR))
    else $error("summary status out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for frame_receiver_crc16_addr_filter, a byte-wise
// deframer with crc-16 check and address filter; needs frc_pkg, frc_chan_if
// and the rtl; random bytes and stalls on both channels, apb register writes
module tb;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam int RANDOM_BYTES_PER_PHASE = 170;

  localparam logic [1:0] RX_WAIT_HDR = 2'd0;
  localparam logic [1:0] RX_FRAME    = 2'd1;
  localparam logic [1:0] RX_BAD_HDR  = 2'd2;
  localparam logic [1:0] RX_DRAIN    = 2'd3;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [frc_pkg::CfgAddrW-1:0] paddr;
  logic [frc_pkg::CfgDataW-1:0] pwdata;
  logic [frc_pkg::CfgDataW-1:0] prdata;
  logic pready;

  frc_chan_if #(.payload_t(frc_pkg::in_item_t)) in_chan ();
  frc_chan_if #(.payload_t(frc_pkg::out_item_t)) out_chan ();

  frame_receiver_crc16_addr_filter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // register shadow and parser state
  frc_pkg::cfg_t cfg_now;
  logic [1:0]  rx_phase;
  logic [8:0]  rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  hold_src;
  logic [7:0]  hold_dest;
  logic [15:0] hold_seq;
  logic [15:0] hold_dom;
  logic [7:0]  hold_type;
  logic [7:0]  hold_flags;
  logic [7:0]  hold_len;
  logic [7:0]  hold_crc_lo;

  frc_pkg::in_item_t  rx_bytes_q[$];
  frc_pkg::out_item_t pending_results[$];
  logic [7:0] frame_buf[$];

  int err_count = 0;
  int queued = 0;
  int bytes_in = 0;
  int payload_seen = 0;
  int status_seen[5];
  int in_gap = 0;
  int out_stall = 0;
  int next_stall;
  bit in_calm = 0;
  bit out_calm = 0;

  always #5 clk = ~clk;

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) begin
      if (r[15]) r = (r << 1) ^ frc_pkg::CRC_POLY;
      else r = r << 1;
    end
    return r;
  endfunction

  function automatic frc_pkg::out_item_t frame_summary(input logic [2:0] st,
                                                       input logic [15:0] rcrc);
    frc_pkg::out_item_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.status = st;
    if (st == frc_pkg::ST_OK || st == frc_pkg::ST_CRC || st == frc_pkg::ST_ADDR) begin
      r.src_address = hold_src;
      r.dest_address = hold_dest;
      r.sequence_res = hold_seq;
      r.domain = hold_dom;
      r.message_type = hold_type;
      r.flags_byte = hold_flags;
      r.payload_length = hold_len;
      r.received_crc = rcrc;
    end
    return r;
  endfunction

  task automatic track_rx_byte(input frc_pkg::in_item_t it);
    frc_pkg::out_item_t r;
    logic        has;
    logic [8:0]  idx;
    logic [15:0] rcrc;
    logic [2:0]  st;
    logic [7:0]  b;
    b = it.data_byte;
    r = '0;
    has = 1'b0;
    unique case (rx_phase)
      RX_WAIT_HDR: begin
        rx_count = 9'd1;
        rx_crc = frc_pkg::CRC_INIT;
        {hold_src, hold_dest, hold_seq, hold_dom} = '0;
        {hold_type, hold_flags, hold_len, hold_crc_lo} = '0;
        if (it.last_byte) begin
          r = frame_summary(frc_pkg::ST_SHORT, 16'h0);
          has = 1'b1;
        end else if (b == cfg_now.header_byte) begin
          rx_crc = crc_ccitt_step(frc_pkg::CRC_INIT, b);
          rx_phase = RX_FRAME;
        end else begin
          rx_phase = RX_BAD_HDR;
        end
      end
      RX_BAD_HDR: begin
        rx_count = rx_count + 9'd1;
        if (rx_count >= frc_pkg::MIN_LEN) begin
          rx_phase = it.last_byte ? RX_WAIT_HDR : RX_DRAIN;
          r = frame_summary(frc_pkg::ST_BADHDR, 16'h0);
          has = 1'b1;
        end else if (it.last_byte) begin
          rx_phase = RX_WAIT_HDR;
          r = frame_summary(frc_pkg::ST_SHORT, 16'h0);
          has = 1'b1;
        end
      end
      RX_DRAIN: begin
        if (it.last_byte) rx_phase = RX_WAIT_HDR;
      end
      default: begin
        idx = rx_count;
        rx_count = rx_count + 9'd1;
        if (idx == frc_pkg::HDR_LEN + {1'b0, hold_len} + 9'd1) begin
          rcrc = {b, hold_crc_lo};
          if (rcrc != rx_crc) st = frc_pkg::ST_CRC;
          else if (hold_dest != cfg_now.local_address &&
                   hold_dest != cfg_now.broadcast_address) st = frc_pkg::ST_ADDR;
          else st = frc_pkg::ST_OK;
          rx_phase = it.last_byte ? RX_WAIT_HDR : RX_DRAIN;
          r = frame_summary(st, rcrc);
          has = 1'b1;
        end else if (it.last_byte) begin
          rx_phase = RX_WAIT_HDR;
          r = frame_summary(frc_pkg::ST_SHORT, 16'h0);
          has = 1'b1;
        end else if (idx < frc_pkg::HDR_LEN) begin
          rx_crc = crc_ccitt_step(rx_crc, b);
          case (idx)
            9'd2: hold_flags = b;
            9'd3: hold_src = b;
            9'd4: hold_dest = b;
            9'd5: hold_seq[7:0] = b;
            9'd6: hold_seq[15:8] = b;
            9'd7: hold_dom[7:0] = b;
            9'd8: hold_dom[15:8] = b;
            9'd9: hold_type = b;
            9'd10: hold_len = b;
            default: ;
          endcase
        end else if (idx < frc_pkg::HDR_LEN + {1'b0, hold_len}) begin
          rx_crc = crc_ccitt_step(rx_crc, b);
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = 8'(idx - frc_pkg::HDR_LEN);
          has = 1'b1;
        end else begin
          hold_crc_lo = b;
        end
      end
    endcase
    if (has) pending_results.push_back(r);
  endtask

  task automatic check_result(input frc_pkg::out_item_t got);
    frc_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: kind %0d status %0d", got.kind, got.status);
      err_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) err_count++;
    if (got.kind !== want.kind)
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
    if (got.payload_byte !== want.payload_byte)
      $error("payload_byte: expected %0d, got %0d", want.payload_byte, got.payload_byte);
    if (got.payload_index !== want.payload_index)
      $error("payload_index: expected %0d, got %0d", want.payload_index, got.payload_index);
    if (got.status !== want.status)
      $error("status: expected %0d, got %0d", want.status, got.status);
    if (got.src_address !== want.src_address)
      $error("src_address: expected %0d, got %0d", want.src_address, got.src_address);
    if (got.dest_address !== want.dest_address)
      $error("dest_address: expected %0d, got %0d", want.dest_address, got.dest_address);
    if (got.sequence_res !== want.sequence_res)
      $error("sequence_res: expected %0d, got %0d", want.sequence_res, got.sequence_res);
    if (got.domain !== want.domain)
      $error("domain: expected %0d, got %0d", want.domain, got.domain);
    if (got.message_type !== want.message_type)
      $error("message_type: expected %0d, got %0d", want.message_type, got.message_type);
    if (got.flags_byte !== want.flags_byte)
      $error("flags_byte: expected %0d, got %0d", want.flags_byte, got.flags_byte);
    if (got.payload_length !== want.payload_length)
      $error("payload_length: expected %0d, got %0d", want.payload_length, got.payload_length);
    if (got.received_crc !== want.received_crc)
      $error("received_crc: expected %0d, got %0d", want.received_crc, got.received_crc);
    if (want.kind == KIND_SUMMARY && want.status <= frc_pkg::ST_ADDR)
      status_seen[want.status]++;
    else payload_seen++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.payload <= '0;
      in_gap <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        track_rx_byte(in_chan.payload);
        bytes_in++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap != 0) begin
          in_chan.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (rx_bytes_q.size() != 0) begin
          in_chan.valid <= 1'b1;
          in_chan.payload <= rx_bytes_q.pop_front();
          if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(0, 8);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      next_stall = (out_stall > 0) ? out_stall - 1 : 0;
      if (out_chan.valid && out_chan.ready) begin
        check_result(out_chan.payload);
        if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
        next_stall = out_calm ? 0 : $urandom_range(0, 8);
      end
      out_stall <= next_stall;
      out_chan.ready <= (next_stall == 0);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      frc_pkg::REG_HEADER_BYTE: cfg_now.header_byte = val;
      frc_pkg::REG_LOCAL_ADDR: cfg_now.local_address = val;
      frc_pkg::REG_BCAST_ADDR: cfg_now.broadcast_address = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] hb, input logic [7:0] la, input logic [7:0] ba);
    reg_write(frc_pkg::REG_HEADER_BYTE, hb);
    reg_write(frc_pkg::REG_LOCAL_ADDR, la);
    reg_write(frc_pkg::REG_BCAST_ADDR, ba);
  endtask

  // fill < 0 gives random header fields and payload
  task automatic build_frame(input logic [7:0] hb, input logic [7:0] dest, input int len,
                             input int fill);
    logic [15:0] c;
    frame_buf.delete();
    frame_buf.push_back(hb);
    for (int k = 1; k < 11; k++)
      frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    frame_buf[4] = dest;
    frame_buf[10] = 8'(len);
    for (int k = 0; k < len; k++)
      frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    c = frc_pkg::CRC_INIT;
    foreach (frame_buf[k]) c = crc_ccitt_step(c, frame_buf[k]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic push_buffer();
    frc_pkg::in_item_t it;
    foreach (frame_buf[k]) begin
      it.data_byte = frame_buf[k];
      it.last_byte = (k == frame_buf.size() - 1);
      rx_bytes_q.push_back(it);
      queued++;
    end
    frame_buf.delete();
  endtask

  task automatic add_noise(input int n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  task automatic truncate_to(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic random_buffer();
    int pick;
    int len;
    int pos;
    logic [7:0] dest;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 49))
      0: len = 255;
      1: len = $urandom_range(16, 254);
      default: len = $urandom_range(0, 15);
    endcase
    case ($urandom_range(0, 3))
      0: dest = cfg_now.local_address;
      1: dest = cfg_now.broadcast_address;
      default: dest = 8'($urandom);
    endcase
    if (pick < 80) build_frame(cfg_now.header_byte, dest, len, -1);
    if (pick >= 60 && pick < 70) begin
      pos = $urandom_range(1, frame_buf.size() - 1);
      frame_buf[pos] = frame_buf[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (pick >= 70 && pick < 80) truncate_to($urandom_range(1, frame_buf.size() - 1));
    else if (pick < 70 && $urandom_range(0, 1) == 0) add_noise($urandom_range(1, 3));
    if (pick >= 80 && pick < 90) begin
      frame_buf.delete();
      frame_buf.push_back(cfg_now.header_byte ^ 8'($urandom_range(1, 255)));
      add_noise($urandom_range(0, 19));
    end
    if (pick >= 90) begin
      frame_buf.delete();
      add_noise($urandom_range(1, 24));
    end
    push_buffer();
  endtask

  task automatic random_phase(input int n);
    int start;
    start = queued;
    while (queued - start < n) random_buffer();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_chan.valid || pending_results.size() != 0);
    // trailing bytes give no result, let the pipe empty
    repeat (6) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_chan.valid = 1'b0;
    in_chan.payload = '0;
    out_chan.ready = 1'b0;
    foreach (status_seen[k]) status_seen[k] = 0;
    cfg_now.header_byte = 8'hAA;
    cfg_now.local_address = 8'h00;
    cfg_now.broadcast_address = 8'hFF;
    rx_phase = RX_WAIT_HDR;
    rx_count = '0;
    rx_crc = frc_pkg::CRC_INIT;
    {hold_src, hold_dest, hold_seq, hold_dom} = '0;
    {hold_type, hold_flags, hold_len, hold_crc_lo} = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    // single-byte buffer that matches the header byte
    frame_buf.push_back(cfg_now.header_byte);
    push_buffer();
    // all-ones header to broadcast, empty payload, trailing bytes
    build_frame(cfg_now.header_byte, cfg_now.broadcast_address, 0, 255);
    add_noise(2);
    push_buffer();
    // all-zero header and payload to local address
    build_frame(cfg_now.header_byte, cfg_now.local_address, 3, 0);
    push_buffer();
    // wrong first byte, long enough for bad header, then one dropped byte
    frame_buf.push_back(~cfg_now.header_byte);
    add_noise(13);
    push_buffer();
    // wrong first byte, buffer too short
    frame_buf.push_back(~cfg_now.header_byte);
    add_noise(4);
    push_buffer();
    // buffer ends on a payload byte
    build_frame(cfg_now.header_byte, cfg_now.local_address, 4, -1);
    truncate_to(13);
    push_buffer();
    // buffer ends inside the header
    build_frame(cfg_now.header_byte, cfg_now.local_address, 4, -1);
    truncate_to(6);
    push_buffer();
    // crc mismatch on a frame that is not addressed either
    build_frame(cfg_now.header_byte, 8'h5A, 1, -1);
    frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h80;
    push_buffer();
    // good crc, not addressed
    build_frame(cfg_now.header_byte, 8'h5A, 0, -1);
    push_buffer();
    random_phase(RANDOM_BYTES_PER_PHASE);
    wait_drained();

    set_config(8'h00, 8'h00, 8'h00);
    build_frame(cfg_now.header_byte, cfg_now.local_address, 255, -1);
    push_buffer();
    random_phase(RANDOM_BYTES_PER_PHASE);
    wait_drained();

    set_config(8'hFF, 8'hFF, 8'hFF);
    random_phase(RANDOM_BYTES_PER_PHASE);
    wait_drained();

    set_config(8'h7E, 8'($urandom), 8'hFF);
    random_phase(RANDOM_BYTES_PER_PHASE);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      set_config(8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(RANDOM_BYTES_PER_PHASE);
      wait_drained();
    end

    $display("tb: %0d bytes in over 6 register settings, %0d payload beats checked",
             bytes_in, payload_seen);
    $display("tb: summaries ok %0d, bad header %0d, short %0d, crc %0d, unaddressed %0d",
             status_seen[frc_pkg::ST_OK], status_seen[frc_pkg::ST_BADHDR],
             status_seen[frc_pkg::ST_SHORT], status_seen[frc_pkg::ST_CRC],
             status_seen[frc_pkg::ST_ADDR]);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
